### rtl/core/slfc_pkg.sv
// Shared types and constants for the serial LED fade controller core.
// Used by the parser, the command queue, the fade engine and the top level.
package slfc_pkg;

  localparam int NUM_CH         = 3;
  localparam int FRAC_BITS      = 8;
  localparam int CMD_FIFO_DEPTH = 2;

  // Start byte decode
  localparam logic [7:0] KIND_MASK = 8'hE0;
  localparam logic [7:0] PKT_ADDR  = 8'h80;
  localparam logic [7:0] PKT_BCAST = 8'hE0;
  localparam logic [7:0] PKT_CLOCK = 8'hC0;

  localparam logic [7:0]  COLOR_MAX    = 8'hFF;
  // x / 255 == (x * 0x8081) >> 23 for every 16-bit x
  localparam logic [15:0] DIV255_RECIP = 16'h8081;
  localparam int          DIV255_SHIFT = 23;

  typedef logic [NUM_CH-1:0][7:0] color_t;  // [0] hue, [1] saturation, [2] value

  typedef enum logic [1:0] {
    KIND_IMMED   = 2'd0,
    KIND_BLACK   = 2'd1,
    KIND_CURRENT = 2'd2,
    KIND_OTHER   = 2'd3
  } cmd_kind_t;

  typedef enum logic [1:0] {
    OP_IMMED    = 2'd0,
    OP_TIMED    = 2'd1,
    OP_RETARGET = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        from_black;
    color_t      target;
    logic [15:0] length;
    logic [4:0]  tick_ms;
  } cmd_t;

endpackage

### rtl/core/slfc_front.sv
// Byte parser: turns received bytes into complete packet commands.
// Depends on slfc_pkg for command and kind types.
module slfc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  input  logic [7:0]    rx_byte,
  input  logic [4:0]    node_address,
  output logic          cmd_valid,
  output slfc_pkg::cmd_t cmd
);
  import slfc_pkg::*;

  typedef enum logic [6:0] {
    PH_WAIT    = 7'b0000001,
    PH_CMD     = 7'b0000010,
    PH_HUE     = 7'b0000100,
    PH_SAT     = 7'b0001000,
    PH_VAL     = 7'b0010000,
    PH_TIME_HI = 7'b0100000,
    PH_TIME_LO = 7'b1000000
  } phase_t;

  phase_t     phase, phase_next;
  cmd_kind_t  kind;
  logic [7:0] hue, sat, val, time_hi;
  logic [7:0] shifted;

  assign shifted = {rx_byte[6:0], 1'b0};

  always_comb begin
    phase_next = phase;
    cmd_valid  = 1'b0;
    cmd        = '0;
    cmd.target = {val, sat, hue};
    case (phase)
      PH_WAIT: begin
        if (rx_byte[7]) begin
          case (rx_byte & KIND_MASK)
            PKT_ADDR: begin
              if (rx_byte[4:0] == node_address) phase_next = PH_CMD;
            end
            PKT_BCAST: phase_next = PH_CMD;
            PKT_CLOCK: begin
              cmd_valid   = 1'b1;
              cmd.op      = OP_TICK;
              cmd.tick_ms = rx_byte[4:0];
            end
            default: ;
          endcase
        end
      end
      PH_CMD:     phase_next = PH_HUE;
      PH_HUE:     phase_next = PH_SAT;
      PH_SAT:     phase_next = PH_VAL;
      PH_VAL: begin
        cmd.target = {shifted, sat, hue};
        if (kind == KIND_BLACK || kind == KIND_CURRENT) begin
          phase_next = PH_TIME_HI;
        end else begin
          phase_next = PH_WAIT;
          cmd_valid  = 1'b1;
          cmd.op     = (kind == KIND_IMMED) ? OP_IMMED : OP_RETARGET;
        end
      end
      PH_TIME_HI: phase_next = PH_TIME_LO;
      PH_TIME_LO: begin
        phase_next     = PH_WAIT;
        cmd_valid      = 1'b1;
        cmd.op         = OP_TIMED;
        cmd.from_black = (kind == KIND_BLACK);
        cmd.length     = {1'b0, time_hi, 7'b0} | {8'b0, rx_byte};
      end
      default: phase_next = PH_WAIT;
    endcase
    if (!byte_valid) begin
      phase_next = phase;
      cmd_valid  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      kind  <= KIND_IMMED;
    end else begin
      phase <= phase_next;
      if (byte_valid && phase == PH_CMD) begin
        kind <= (rx_byte <= 8'(KIND_CURRENT)) ? cmd_kind_t'(rx_byte[1:0]) : KIND_OTHER;
      end
    end
  end

  // Color and time bytes: payload only
  always_ff @(posedge clk) begin
    if (byte_valid) begin
      if (phase == PH_HUE)     hue     <= shifted;
      if (phase == PH_SAT)     sat     <= shifted;
      if (phase == PH_VAL)     val     <= shifted;
      if (phase == PH_TIME_HI) time_hi <= rx_byte;
    end
  end

endmodule

### rtl/core/slfc_cmd_fifo.sv
// Short command queue between the parser and the fade engine.
// Depends on slfc_pkg for the command type.
module slfc_cmd_fifo #(
  parameter int Depth = slfc_pkg::CMD_FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  slfc_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output slfc_pkg::cmd_t rd_data,
  output logic           full,
  output logic           empty
);
  import slfc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) entries[wr_ptr] <= wr_data;
  end

endmodule

### rtl/core/slfc_back.sv
// Fade engine: executes packet commands, keeps the color and time state,
// divides for the fade fraction and mixes one channel at a time. Uses slfc_pkg.
module slfc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_empty,
  input  slfc_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     hue,
  output logic [7:0]     saturation,
  output logic [7:0]     brightness,
  output logic           fade_active
);
  import slfc_pkg::*;

  typedef enum logic [4:0] {
    BK_IDLE  = 5'b00001,
    BK_DIV   = 5'b00010,
    BK_MIX   = 5'b00100,
    BK_SCALE = 5'b01000,
    BK_EMIT  = 5'b10000
  } bk_state_t;

  bk_state_t   state;
  color_t      target, start, current, out_color, black_start;
  logic [15:0] elapsed, length, elapsed_sum;
  logic [15:0] rem, mix;
  logic [16:0] rem_shift, mix_sum;
  logic [7:0]  frac, inv_frac;
  logic [2:0]  step;
  logic [1:0]  ch;
  logic [31:0] scale_prod;
  logic        out_valid, out_fade, out_free, qbit, out_load;

  assign empty       = !out_valid;
  assign hue         = out_color[0];
  assign saturation  = out_color[1];
  assign brightness  = out_color[2];
  assign fade_active = out_fade;

  assign out_free = !out_valid || pop;
  assign cmd_pop  = (state == BK_IDLE) && !cmd_empty && out_free;

  assign elapsed_sum = elapsed + {11'b0, cmd.tick_ms};

  // Restoring divide step: remainder stays below the fade length
  assign rem_shift = {rem, 1'b0};
  assign qbit      = (rem_shift >= {1'b0, length});

  assign inv_frac   = COLOR_MAX - frac;
  assign mix_sum    = {1'b0, {8'b0, start[ch]} * {8'b0, inv_frac}} +
                      {1'b0, {8'b0, target[ch]} * {8'b0, frac}};
  assign scale_prod = {16'b0, mix} * {16'b0, DIV255_RECIP};

  always_comb begin
    black_start    = cmd.target;
    black_start[2] = (cmd.length == '0) ? cmd.target[2] : 8'h00;
  end

  // Load the output register on every command or tick that emits a color
  always_comb begin
    out_load = 1'b0;
    if (state == BK_EMIT) begin
      out_load = 1'b1;
    end else if (cmd_pop) begin
      case (cmd.op)
        OP_TICK:  out_load = (length != '0) && (elapsed_sum >= length);
        OP_IMMED: out_load = 1'b1;
        OP_TIMED: out_load = 1'b1;
        default:  out_load = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      target    <= '0;
      start     <= '0;
      current   <= '0;
      elapsed   <= '0;
      length    <= '0;
    end else begin
      out_valid <= out_load || (out_valid && !pop);
      case (state)
        BK_IDLE: begin
          if (cmd_pop) begin
            case (cmd.op)
              OP_TICK: begin
                elapsed <= elapsed_sum;
                if (length != '0) begin
                  if (elapsed_sum < length) begin
                    rem   <= elapsed_sum;
                    frac  <= '0;
                    step  <= '0;
                    state <= BK_DIV;
                  end else begin
                    length    <= '0;
                    current   <= target;
                    out_color <= target;
                    out_fade  <= 1'b0;
                  end
                end
              end
              OP_IMMED: begin
                elapsed   <= '0;
                target    <= cmd.target;
                length    <= '0;
                start     <= cmd.target;
                current   <= cmd.target;
                out_color <= cmd.target;
                out_fade  <= 1'b0;
              end
              OP_TIMED: begin
                elapsed   <= '0;
                target    <= cmd.target;
                length    <= cmd.length;
                if (cmd.from_black) begin
                  start     <= black_start;
                  current   <= black_start;
                  out_color <= black_start;
                  out_fade  <= (cmd.length != '0);
                end else if (cmd.length == '0) begin
                  start     <= cmd.target;
                  current   <= cmd.target;
                  out_color <= cmd.target;
                  out_fade  <= 1'b0;
                end else begin
                  start     <= current;
                  out_color <= current;
                  out_fade  <= 1'b1;
                end
              end
              OP_RETARGET: begin
                elapsed <= '0;
                target  <= cmd.target;
              end
              default: ;
            endcase
          end
        end
        BK_DIV: begin
          rem  <= qbit ? 16'(rem_shift - {1'b0, length}) : rem_shift[15:0];
          frac <= {frac[6:0], qbit};
          step <= step + 1'b1;
          if (step == 3'(FRAC_BITS - 1)) begin
            ch    <= '0;
            state <= BK_MIX;
          end
        end
        BK_MIX: begin
          mix   <= mix_sum[15:0];
          state <= BK_SCALE;
        end
        BK_SCALE: begin
          current[ch] <= scale_prod[DIV255_SHIFT+7:DIV255_SHIFT];
          if (ch == 2'(NUM_CH - 1)) begin
            state <= BK_EMIT;
          end else begin
            ch    <= ch + 1'b1;
            state <= BK_MIX;
          end
        end
        BK_EMIT: begin
          out_color <= current;
          out_fade  <= 1'b1;
          state     <= BK_IDLE;
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/serial_led_fade_controller_core.sv
// Serial LED fade controller core: parses received bytes into light packets
// and produces the HSV color to show. Parser takes one item per cycle unless
// the queue is full; a command queue decouples it from the fade engine. An
// interpolating tick runs an 8-step fraction divide, then a mix and a scale
// step per channel and an emit; others finish in idle. Synchronous active
// high reset clears the parser, queue, color/time state and node address.
module serial_led_fade_controller_core #(
  parameter int CmdDepth = slfc_pkg::CMD_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // Byte input
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  // Color results
  output logic       empty,
  input  logic       pop,
  output logic [7:0] hue,
  output logic [7:0] saturation,
  output logic [7:0] brightness,
  output logic       fade_active,
  // Node address register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);
  import slfc_pkg::*;

  logic [4:0] node_address;
  logic       byte_valid;
  logic       front_valid;
  cmd_t       front_cmd;
  cmd_t       queue_cmd;
  logic       queue_full, queue_empty, queue_pop;

  // Address register takes a write in any cycle; the parser reads it only
  // when a start byte arrives
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      node_address <= cfg_data;
    end
  end

  // Hold off the byte stream whenever the queue cannot take one more command,
  // so every byte that might finish a packet always has a slot
  assign full       = queue_full;
  assign byte_valid = push && !full;

  slfc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .rx_byte      (rx_byte),
    .node_address (node_address),
    .cmd_valid    (front_valid),
    .cmd          (front_cmd)
  );

  slfc_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_cmd),
    .rd_en   (queue_pop),
    .rd_data (queue_cmd),
    .full    (queue_full),
    .empty   (queue_empty)
  );

  // Engine drains the queue and owns the output register
  slfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (queue_empty),
    .cmd         (queue_cmd),
    .cmd_pop     (queue_pop),
    .pop         (pop),
    .empty       (empty),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness),
    .fade_active (fade_active)
  );

endmodule
